FILE: rtl/blg_pkg.sv
// blg_pkg: shared widths, register map, reset values, codes and types of the
// battery level gauge. No dependencies; every rtl file but blg_fifo refers to it by scope.
package blg_pkg;

	localparam int ADC_W      = 12;
	localparam int MV_CFG_W   = 13;
	localparam int THR_W      = 12;
	localparam int SAT_W      = 13;
	localparam int CAL_W      = 16;
	localparam int LEVEL_W    = 8;
	localparam int STATUS_W   = 2;
	localparam int MV_OUT_W   = 16;

	localparam int AVG_SAMPLES_DEF = 4;
	localparam int JOB_DEPTH_DEF   = 2;

	// calibration product avg*gain and divider dividend; divisor up to full-empty span
	localparam int DIV_W = ADC_W + CAL_W;
	localparam int DVS_W = MV_CFG_W;
	// computed voltage before output saturation
	localparam int MV_W  = 19;

	localparam int APB_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE,
		REG_FULL_MV,
		REG_EMPTY_MV,
		REG_DETECT_THR,
		REG_SAT_LIMIT,
		REG_CAL_GAIN,
		REG_CAL_OFFSET
	} reg_idx_t;

	localparam logic                RST_MODE       = 1'b0;
	localparam logic [MV_CFG_W-1:0] RST_FULL_MV    = 13'd4200;
	localparam logic [MV_CFG_W-1:0] RST_EMPTY_MV   = 13'd3600;
	localparam logic [THR_W-1:0]    RST_DETECT_THR = 12'd300;
	localparam logic [SAT_W-1:0]    RST_SAT_LIMIT  = 13'd4000;
	localparam logic [CAL_W-1:0]    RST_CAL_GAIN   = 16'd4242;
	localparam logic [CAL_W-1:0]    RST_CAL_OFFSET = 16'd6590;

	localparam logic MODE_EXTERNAL = 1'b0;
	localparam logic MODE_INTERNAL = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_DIV = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 8'd0;

	localparam int INT_K_W = 14;
	localparam logic [INT_K_W-1:0]  INT_MV_SCALE = 14'd12600;
	localparam int                  INT_MV_SHIFT = 12;
	localparam logic [MV_CFG_W-1:0] INT_EMPTY_MV = 13'd3000;
	localparam logic [MV_CFG_W-1:0] INT_FULL_MV  = 13'd4200;
	localparam logic [6:0]          PERCENT      = 7'd100;

	// floor(x / 1000) for any x below 2**DIV_W as (x * CAL_RECIP) >> CAL_SHIFT
	localparam int                     CAL_RECIP_W = 29;
	localparam logic [CAL_RECIP_W-1:0] CAL_RECIP   = 29'd274877907;
	localparam int                     CAL_SHIFT   = 38;

	typedef struct packed {
		logic                mode;
		logic [MV_CFG_W-1:0] full_mv;
		logic [MV_CFG_W-1:0] empty_mv;
		logic [THR_W-1:0]    detect_threshold;
		logic [SAT_W-1:0]    saturation_limit;
		logic [CAL_W-1:0]    cal_gain;
		logic [CAL_W-1:0]    cal_offset;
	} cfg_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_INT_MUL,
		BS_AVG,
		BS_CHECK,
		BS_CAL_MUL,
		BS_SCALE,
		BS_OFFSET,
		BS_MAP,
		BS_MAP_MUL,
		BS_DIV_GO,
		BS_DIV_WAIT,
		BS_EMIT
	} back_state_t;

endpackage

FILE: rtl/blg_regs.sv
// blg_regs: APB configuration registers of the battery level gauge.
// Depends on blg_pkg for the register map and reset values.
module blg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [blg_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [blg_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [blg_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output blg_pkg::cfg_t                     cfg
);

	blg_pkg::cfg_t     cfg_q;
	blg_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = blg_pkg::reg_idx_t'(paddr[blg_pkg::CFG_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode             <= blg_pkg::RST_MODE;
			cfg_q.full_mv          <= blg_pkg::RST_FULL_MV;
			cfg_q.empty_mv         <= blg_pkg::RST_EMPTY_MV;
			cfg_q.detect_threshold <= blg_pkg::RST_DETECT_THR;
			cfg_q.saturation_limit <= blg_pkg::RST_SAT_LIMIT;
			cfg_q.cal_gain         <= blg_pkg::RST_CAL_GAIN;
			cfg_q.cal_offset       <= blg_pkg::RST_CAL_OFFSET;
		end else if (wr_en) begin
			case (idx)
				blg_pkg::REG_MODE:       cfg_q.mode <= pwdata[0];
				blg_pkg::REG_FULL_MV:    cfg_q.full_mv <= pwdata[blg_pkg::MV_CFG_W-1:0];
				blg_pkg::REG_EMPTY_MV:   cfg_q.empty_mv <= pwdata[blg_pkg::MV_CFG_W-1:0];
				blg_pkg::REG_DETECT_THR: cfg_q.detect_threshold <= pwdata[blg_pkg::THR_W-1:0];
				blg_pkg::REG_SAT_LIMIT:  cfg_q.saturation_limit <= pwdata[blg_pkg::SAT_W-1:0];
				blg_pkg::REG_CAL_GAIN:   cfg_q.cal_gain <= pwdata[blg_pkg::CAL_W-1:0];
				blg_pkg::REG_CAL_OFFSET: cfg_q.cal_offset <= pwdata[blg_pkg::CAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			blg_pkg::REG_MODE:       prdata = blg_pkg::APB_DATA_W'(cfg_q.mode);
			blg_pkg::REG_FULL_MV:    prdata = blg_pkg::APB_DATA_W'(cfg_q.full_mv);
			blg_pkg::REG_EMPTY_MV:   prdata = blg_pkg::APB_DATA_W'(cfg_q.empty_mv);
			blg_pkg::REG_DETECT_THR: prdata = blg_pkg::APB_DATA_W'(cfg_q.detect_threshold);
			blg_pkg::REG_SAT_LIMIT:  prdata = blg_pkg::APB_DATA_W'(cfg_q.saturation_limit);
			blg_pkg::REG_CAL_GAIN:   prdata = blg_pkg::APB_DATA_W'(cfg_q.cal_gain);
			blg_pkg::REG_CAL_OFFSET: prdata = blg_pkg::APB_DATA_W'(cfg_q.cal_offset);
			default:                 prdata = '0;
		endcase
	end

endmodule

FILE: rtl/blg_front.sv
// blg_front: takes ADC samples, accumulates idle and gated sums and hands
// finished measurements or internal samples on as jobs. Depends on blg_pkg.
module blg_front #(
	parameter int AVG_SAMPLES = blg_pkg::AVG_SAMPLES_DEF,
	parameter int SUM_W       = blg_pkg::ADC_W + $clog2(AVG_SAMPLES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_mode,
	input  logic                     push,
	output logic                     full,
	input  logic [blg_pkg::ADC_W-1:0] sample,
	input  logic                     gate_on,
	input  logic                     job_full,
	output logic                     job_push,
	output logic                     job_int,
	output logic [SUM_W-1:0]         job_idle_sum,
	output logic [SUM_W-1:0]         job_gated_sum
);

	localparam int CNT_W = $clog2(AVG_SAMPLES + 1);

	logic [SUM_W-1:0] idle_sum_q;
	logic [SUM_W-1:0] gated_sum_q;
	logic [CNT_W-1:0] idle_cnt_q;
	logic [CNT_W-1:0] gated_cnt_q;

	logic             accept;
	logic             idle_full;
	logic             gate_done;
	logic             ext_accept;
	logic [SUM_W-1:0] gated_sum_nxt;

	assign full          = job_full;
	assign accept        = push & ~job_full;
	assign ext_accept    = accept & (cfg_mode == blg_pkg::MODE_EXTERNAL);
	assign idle_full     = idle_cnt_q >= CNT_W'(AVG_SAMPLES);
	assign gate_done     = (gated_cnt_q + 1'b1) == CNT_W'(AVG_SAMPLES);
	assign gated_sum_nxt = gated_sum_q + SUM_W'(sample);

	// internal jobs carry the raw sample in the gated sum slot
	assign job_int       = (cfg_mode == blg_pkg::MODE_INTERNAL);
	assign job_push      = accept & (job_int | (gate_on & idle_full & gate_done));
	assign job_idle_sum  = idle_sum_q;
	assign job_gated_sum = job_int ? SUM_W'(sample) : gated_sum_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_sum_q  <= '0;
			gated_sum_q <= '0;
			idle_cnt_q  <= '0;
			gated_cnt_q <= '0;
		end else if (ext_accept) begin
			if (!gate_on) begin
				// late idle sample restarts the measurement
				if ((gated_cnt_q != '0) || idle_full) begin
					idle_sum_q  <= SUM_W'(sample);
					idle_cnt_q  <= CNT_W'(1);
					gated_sum_q <= '0;
					gated_cnt_q <= '0;
				end else begin
					idle_sum_q <= idle_sum_q + SUM_W'(sample);
					idle_cnt_q <= idle_cnt_q + 1'b1;
				end
			end else if (idle_full) begin
				if (gate_done) begin
					idle_sum_q  <= '0;
					idle_cnt_q  <= '0;
					gated_sum_q <= '0;
					gated_cnt_q <= '0;
				end else begin
					gated_sum_q <= gated_sum_nxt;
					gated_cnt_q <= gated_cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/blg_fifo.sv
// blg_fifo: small first-word-fall-through job queue between front and back.
// Depends on nothing but its parameters.
module blg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/blg_div.sv
// blg_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on blg_pkg for the operand widths.
module blg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [blg_pkg::DIV_W-1:0] dividend,
	input  logic [blg_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [blg_pkg::DIV_W-1:0] quotient
);

	localparam int DIV_W = blg_pkg::DIV_W;
	localparam int DVS_W = blg_pkg::DVS_W;
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W:0]   trial_sub;

	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign ge        = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign done      = done_q;
	assign quotient  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/blg_back.sv
// blg_back: sequencer that averages, checks, calibrates and maps a measurement job, or scales
// and maps an internal one; holds the stored level and the result register. Uses blg_pkg, blg_div.
module blg_back #(
	parameter int AVG_SAMPLES = blg_pkg::AVG_SAMPLES_DEF,
	parameter int SUM_W       = blg_pkg::ADC_W + $clog2(AVG_SAMPLES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  blg_pkg::cfg_t                cfg,
	input  logic                         job_valid,
	input  logic                         job_int,
	input  logic [SUM_W-1:0]             job_idle_sum,
	input  logic [SUM_W-1:0]             job_gated_sum,
	output logic                         job_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [blg_pkg::LEVEL_W-1:0]  level,
	output logic [blg_pkg::STATUS_W-1:0] status,
	output logic                         changed,
	output logic [blg_pkg::MV_OUT_W-1:0] millivolts
);

	localparam int ADC_W     = blg_pkg::ADC_W;
	localparam int DIV_W     = blg_pkg::DIV_W;
	localparam int DVS_W     = blg_pkg::DVS_W;
	localparam int MV_W      = blg_pkg::MV_W;
	localparam int MV_CFG_W  = blg_pkg::MV_CFG_W;
	localparam int LEVEL_W   = blg_pkg::LEVEL_W;
	localparam int INT_P_W   = ADC_W + blg_pkg::INT_K_W;
	localparam int SCALE_P_W = DIV_W + blg_pkg::CAL_RECIP_W;

	// average by reciprocal, exact for any sum below 2**SUM_W
	localparam int AVG_LOG   = $clog2(AVG_SAMPLES);
	localparam int AVG_SHIFT = SUM_W + AVG_LOG;
	localparam int RCP_W     = SUM_W + 1;
	localparam int AVG_P_W   = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] AVG_RECIP = RCP_W'(((64'd1 << AVG_SHIFT)
		+ 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

	blg_pkg::back_state_t state_q, state_nxt;

	logic                         int_q;
	logic [SUM_W-1:0]             idle_sum_q;
	logic [SUM_W-1:0]             gated_sum_q;
	logic [ADC_W-1:0]             idle_avg_q;
	logic [ADC_W-1:0]             gated_avg_q;
	logic [DIV_W-1:0]             prod_q;
	logic [MV_W-1:0]              mv_q;
	logic [LEVEL_W-1:0]           res_level_q;
	logic [blg_pkg::STATUS_W-1:0] res_status_q;
	logic [LEVEL_W-1:0]           level_reg_q;
	logic                         out_valid_q;
	logic [LEVEL_W-1:0]           out_level_q;
	logic [blg_pkg::STATUS_W-1:0] out_status_q;
	logic                         out_changed_q;
	logic [blg_pkg::MV_OUT_W-1:0] out_mv_q;

	logic                div_start;
	logic                div_done;
	logic [DIV_W-1:0]    div_dividend;
	logic [DVS_W-1:0]    div_divisor;
	logic [DIV_W-1:0]    div_quotient;

	logic [MV_CFG_W-1:0] lo_mv;
	logic [MV_CFG_W-1:0] hi_mv;
	logic                mv_ge_hi;
	logic                mv_le_lo;
	logic [ADC_W-1:0]    avg_diff;
	logic                no_div;
	logic                saturated;
	logic [INT_P_W-1:0]  int_prod;
	logic [AVG_P_W-1:0]  idle_avg_prod;
	logic [AVG_P_W-1:0]  gated_avg_prod;
	logic [DIV_W-1:0]    cal_prod;
	logic [SCALE_P_W-1:0] scale_prod;
	logic [MV_CFG_W-1:0] mv_span;
	logic [DIV_W-1:0]    map_prod;
	logic                emit_fire;

	blg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign lo_mv    = int_q ? blg_pkg::INT_EMPTY_MV : cfg.empty_mv;
	assign hi_mv    = int_q ? blg_pkg::INT_FULL_MV : cfg.full_mv;
	assign mv_ge_hi = mv_q >= MV_W'(hi_mv);
	assign mv_le_lo = mv_q <= MV_W'(lo_mv);

	assign avg_diff  = (gated_avg_q > idle_avg_q) ? gated_avg_q - idle_avg_q
	                                              : idle_avg_q - gated_avg_q;
	assign no_div    = avg_diff < cfg.detect_threshold;
	assign saturated = blg_pkg::SAT_W'(gated_avg_q) >= cfg.saturation_limit;

	assign int_prod       = gated_sum_q[ADC_W-1:0] * blg_pkg::INT_MV_SCALE;
	assign idle_avg_prod  = idle_sum_q * AVG_RECIP;
	assign gated_avg_prod = gated_sum_q * AVG_RECIP;
	assign cal_prod       = gated_avg_q * cfg.cal_gain;
	assign scale_prod     = prod_q * blg_pkg::CAL_RECIP;
	// only reached with lo < mv < hi, so the low bits hold mv exactly
	assign mv_span  = mv_q[MV_CFG_W-1:0] - lo_mv;
	assign map_prod = DIV_W'(mv_span) * DIV_W'(blg_pkg::PERCENT);

	assign div_dividend = prod_q;
	assign div_divisor  = hi_mv - lo_mv;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			blg_pkg::BS_IDLE: begin
				if (job_valid) begin
					state_nxt = job_int ? blg_pkg::BS_INT_MUL : blg_pkg::BS_AVG;
				end
			end
			blg_pkg::BS_INT_MUL: state_nxt = blg_pkg::BS_MAP;
			blg_pkg::BS_AVG:     state_nxt = blg_pkg::BS_CHECK;
			blg_pkg::BS_CHECK: begin
				state_nxt = (no_div || saturated) ? blg_pkg::BS_EMIT : blg_pkg::BS_CAL_MUL;
			end
			blg_pkg::BS_CAL_MUL: state_nxt = blg_pkg::BS_SCALE;
			blg_pkg::BS_SCALE:   state_nxt = blg_pkg::BS_OFFSET;
			blg_pkg::BS_OFFSET:  state_nxt = blg_pkg::BS_MAP;
			blg_pkg::BS_MAP: begin
				state_nxt = (mv_ge_hi || mv_le_lo) ? blg_pkg::BS_EMIT : blg_pkg::BS_MAP_MUL;
			end
			blg_pkg::BS_MAP_MUL: state_nxt = blg_pkg::BS_DIV_GO;
			blg_pkg::BS_DIV_GO:  state_nxt = blg_pkg::BS_DIV_WAIT;
			blg_pkg::BS_DIV_WAIT: begin
				if (div_done) begin
					state_nxt = blg_pkg::BS_EMIT;
				end
			end
			blg_pkg::BS_EMIT: begin
				if (!out_valid_q) begin
					state_nxt = blg_pkg::BS_IDLE;
				end
			end
			default: state_nxt = blg_pkg::BS_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		div_start = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			blg_pkg::BS_IDLE:   job_pop = job_valid;
			blg_pkg::BS_DIV_GO: div_start = 1'b1;
			blg_pkg::BS_EMIT:   emit_fire = ~out_valid_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= blg_pkg::BS_IDLE;
			level_reg_q <= blg_pkg::LEVEL_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit_fire) begin
				level_reg_q <= res_level_q;
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			blg_pkg::BS_IDLE: begin
				if (job_valid) begin
					int_q       <= job_int;
					idle_sum_q  <= job_idle_sum;
					gated_sum_q <= job_gated_sum;
				end
			end
			blg_pkg::BS_INT_MUL: begin
				mv_q <= MV_W'(int_prod >> blg_pkg::INT_MV_SHIFT);
			end
			blg_pkg::BS_AVG: begin
				idle_avg_q  <= idle_avg_prod[AVG_SHIFT +: ADC_W];
				gated_avg_q <= gated_avg_prod[AVG_SHIFT +: ADC_W];
			end
			blg_pkg::BS_CHECK: begin
				if (no_div) begin
					res_level_q  <= blg_pkg::LEVEL_NONE;
					res_status_q <= blg_pkg::STATUS_NO_DIV;
					mv_q         <= '0;
				end else if (saturated) begin
					res_level_q  <= level_reg_q;
					res_status_q <= blg_pkg::STATUS_SAT;
					mv_q         <= '0;
				end
			end
			blg_pkg::BS_CAL_MUL: prod_q <= cal_prod;
			blg_pkg::BS_SCALE:   mv_q <= scale_prod[blg_pkg::CAL_SHIFT +: MV_W];
			blg_pkg::BS_OFFSET: begin
				mv_q <= (mv_q > MV_W'(cfg.cal_offset)) ? mv_q - MV_W'(cfg.cal_offset) : '0;
			end
			blg_pkg::BS_MAP: begin
				if (mv_ge_hi) begin
					res_level_q  <= blg_pkg::LEVEL_FULL;
					res_status_q <= blg_pkg::STATUS_OK;
				end else if (mv_le_lo) begin
					res_level_q  <= blg_pkg::LEVEL_EMPTY;
					res_status_q <= blg_pkg::STATUS_OK;
				end
			end
			blg_pkg::BS_MAP_MUL: prod_q <= map_prod;
			blg_pkg::BS_DIV_WAIT: begin
				if (div_done) begin
					res_level_q  <= div_quotient[LEVEL_W-1:0];
					res_status_q <= blg_pkg::STATUS_OK;
				end
			end
			blg_pkg::BS_EMIT: begin
				if (!out_valid_q) begin
					out_level_q   <= res_level_q;
					out_status_q  <= res_status_q;
					out_changed_q <= res_level_q != level_reg_q;
					out_mv_q      <= (mv_q > MV_W'({blg_pkg::MV_OUT_W{1'b1}}))
					                 ? {blg_pkg::MV_OUT_W{1'b1}}
					                 : mv_q[blg_pkg::MV_OUT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign empty      = ~out_valid_q;
	assign level      = out_level_q;
	assign status     = out_status_q;
	assign changed    = out_changed_q;
	assign millivolts = out_mv_q;

endmodule

FILE: rtl/battery_level_gauge.sv
// battery_level_gauge: top level; ties the APB registers, the sample front
// end, the job queue and the conversion back end together. Uses blg_pkg.
//
// Samples come in on a queue-style port: a request is taken on a clock edge
// with push high and full low. Results leave the same way: the oldest result
// sits on level/status/changed/millivolts while empty is low and is taken on
// an edge with pop high. Registers are written over APB (pready tied high).
// The user must write them only while no request is in flight; nothing checks this.
// In external mode a result appears only for the last gated sample of a
// measurement; idle and early gated samples give none. Internal mode gives
// one result per sample.
// The back end takes one job at a time from the queue and takes the next only
// after the result of the last has gone into the output register; the percent
// mapping waits on the 28-step divider.
// The front end keeps accepting samples while the back end works, until the
// two-entry job queue fills; full is then high. A result not yet popped holds
// the back end, not the front end. Reset clears the sums, sets the stored
// level to 255, empties the queue and loads the register defaults.
module battery_level_gauge #(
	parameter int AVG_SAMPLES = blg_pkg::AVG_SAMPLES_DEF,
	parameter int JOB_DEPTH   = blg_pkg::JOB_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [blg_pkg::ADC_W-1:0]      sample,
	input  logic                           gate_on,
	output logic                           empty,
	input  logic                           pop,
	output logic [blg_pkg::LEVEL_W-1:0]    level,
	output logic [blg_pkg::STATUS_W-1:0]   status,
	output logic                           changed,
	output logic [blg_pkg::MV_OUT_W-1:0]   millivolts,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [blg_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [blg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [blg_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int SUM_W = blg_pkg::ADC_W + $clog2(AVG_SAMPLES);
	localparam int JOB_W = 1 + 2 * SUM_W;

	blg_pkg::cfg_t    cfg;
	logic             job_full;
	logic             job_push;
	logic             f_int;
	logic [SUM_W-1:0] f_idle_sum;
	logic [SUM_W-1:0] f_gated_sum;
	logic [JOB_W-1:0] q_rdata;
	logic             q_empty;
	logic             job_pop;

	blg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	blg_front #(
		.AVG_SAMPLES (AVG_SAMPLES),
		.SUM_W       (SUM_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_mode      (cfg.mode),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.gate_on       (gate_on),
		.job_full      (job_full),
		.job_push      (job_push),
		.job_int       (f_int),
		.job_idle_sum  (f_idle_sum),
		.job_gated_sum (f_gated_sum)
	);

	blg_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  ({f_int, f_idle_sum, f_gated_sum}),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	blg_back #(
		.AVG_SAMPLES (AVG_SAMPLES),
		.SUM_W       (SUM_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.job_valid     (~q_empty),
		.job_int       (q_rdata[JOB_W-1]),
		.job_idle_sum  (q_rdata[2*SUM_W-1:SUM_W]),
		.job_gated_sum (q_rdata[SUM_W-1:0]),
		.job_pop       (job_pop),
		.empty         (empty),
		.pop           (pop),
		.level         (level),
		.status        (status),
		.changed       (changed),
		.millivolts    (millivolts)
	);

`ifndef SYNTHESIS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == blg_pkg::STATUS_OK) |-> level <= blg_pkg::LEVEL_FULL)
		else $error("computed level above full scale");

	a_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == blg_pkg::STATUS_NO_DIV)
		|-> (level == blg_pkg::LEVEL_NONE && millivolts == '0))
		else $error("no-divider result carries a level or voltage");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == blg_pkg::STATUS_SAT) |-> (!changed && millivolts == '0))
		else $error("saturated result changed the level");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for battery_level_gauge; a local model of the gauge
// predicts every reading while samples and apb writes are driven at random.
// Depends on blg_pkg and the battery_level_gauge rtl.
module tb;
	import blg_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int IDLE_PCT      = 37;
	localparam int AVG_N         = 4;
	localparam int ADC_MAX       = 4095;
	localparam logic GATE_OFF    = 1'b0;
	localparam logic GATE_ON     = 1'b1;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [ADC_W-1:0] sample;
		logic             gate_on;
	} adc_req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]  level;
		logic [STATUS_W-1:0] status;
		logic                changed;
		logic [MV_OUT_W-1:0] millivolts;
	} reading_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [ADC_W-1:0]      sample = '0;
	logic                  gate_on = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [LEVEL_W-1:0]    level;
	logic [STATUS_W-1:0]   status;
	logic                  changed;
	logic [MV_OUT_W-1:0]   millivolts;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	adc_req_t    samples_pending[$];
	reading_t    readings_due[$];
	int          mismatches = 0;
	int          samples_queued = 0;
	int          cycles = 0;
	bit          steady = 1'b0;

	cfg_t        gauge_cfg;
	int unsigned stored_level;
	int unsigned idle_sum, gated_sum, idle_cnt, gated_cnt;

	battery_level_gauge dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .sample(sample), .gate_on(gate_on),
		.empty(empty), .pop(pop), .level(level), .status(status),
		.changed(changed), .millivolts(millivolts),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	function automatic int unsigned map_percent(int unsigned mv, int unsigned lo,
			int unsigned hi);
		if (mv >= hi)
			return 100;
		if (mv <= lo)
			return 0;
		return ((mv - lo) * 100) / (hi - lo);
	endfunction

	function automatic void post_reading(int unsigned lvl, logic [STATUS_W-1:0] st,
			logic chg, int unsigned mv);
		reading_t r;
		r.level      = lvl[LEVEL_W-1:0];
		r.status     = st;
		r.changed    = chg;
		r.millivolts = (mv > 65535) ? 16'hFFFF : mv[MV_OUT_W-1:0];
		readings_due.push_back(r);
	endfunction

	task automatic clear_sums();
		idle_sum  = 0;
		gated_sum = 0;
		idle_cnt  = 0;
		gated_cnt = 0;
	endtask

	task automatic reset_model();
		gauge_cfg.mode             = MODE_EXTERNAL;
		gauge_cfg.full_mv          = 13'd4200;
		gauge_cfg.empty_mv         = 13'd3600;
		gauge_cfg.detect_threshold = 12'd300;
		gauge_cfg.saturation_limit = 13'd4000;
		gauge_cfg.cal_gain         = 16'd4242;
		gauge_cfg.cal_offset       = 16'd6590;
		stored_level = 255;
		clear_sums();
	endtask

	task automatic compute_reading(input logic [ADC_W-1:0] s, input logic g);
		int unsigned sv, mv, lvl, ia, ga, diff, scaled;
		sv = s;
		if (gauge_cfg.mode == MODE_INTERNAL) begin
			mv  = sv * 12600 / 4096;
			lvl = map_percent(mv, 3000, 4200);
			post_reading(lvl, STATUS_OK, lvl != stored_level, mv);
			stored_level = lvl;
			return;
		end
		if (g == GATE_OFF) begin
			if (gated_cnt != 0 || idle_cnt >= AVG_N)
				clear_sums();
			idle_sum += sv;
			idle_cnt++;
			return;
		end
		if (idle_cnt < AVG_N)
			return;
		gated_sum += sv;
		gated_cnt++;
		if (gated_cnt < AVG_N)
			return;
		ia = idle_sum / AVG_N;
		ga = gated_sum / AVG_N;
		clear_sums();
		diff = (ga > ia) ? ga - ia : ia - ga;
		if (diff < gauge_cfg.detect_threshold) begin
			post_reading(255, STATUS_NO_DIV, stored_level != 255, 0);
			stored_level = 255;
			return;
		end
		if (ga >= gauge_cfg.saturation_limit) begin
			post_reading(stored_level, STATUS_SAT, 1'b0, 0);
			return;
		end
		scaled = ga * gauge_cfg.cal_gain / 1000;
		mv     = (scaled > gauge_cfg.cal_offset) ? scaled - gauge_cfg.cal_offset : 0;
		lvl    = map_percent(mv, gauge_cfg.empty_mv, gauge_cfg.full_mv);
		post_reading(lvl, STATUS_OK, lvl != stored_level, mv);
		stored_level = lvl;
	endtask

	// sender: one request presented at a time, prediction on acceptance
	always @(posedge clk) begin : sender
		adc_req_t nxt;
		if (push && !full)
			compute_reading(sample, gate_on);
		if (!push || !full) begin
			if (arst_n && samples_pending.size() != 0 &&
					(steady || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = samples_pending.pop_front();
				push    <= 1'b1;
				sample  <= nxt.sample;
				gate_on <= nxt.gate_on;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : receiver
		reading_t want;
		if (arst_n && pop && !empty) begin
			if (readings_due.size() == 0) begin
				$display("%0t: unexpected reading level %0d status %0d changed %0d mv %0d",
					$time, level, status, changed, millivolts);
				mismatches++;
			end else begin
				want = readings_due.pop_front();
				if (level !== want.level) begin
					$display("%0t: level expected %0d actual %0d", $time, want.level, level);
					mismatches++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						status);
					mismatches++;
				end
				if (changed !== want.changed) begin
					$display("%0t: changed expected %0d actual %0d", $time, want.changed,
						changed);
					mismatches++;
				end
				if (millivolts !== want.millivolts) begin
					$display("%0t: millivolts expected %0d actual %0d", $time,
						want.millivolts, millivolts);
					mismatches++;
				end
			end
		end
		pop <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAIL battery_level_gauge");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MODE:       gauge_cfg.mode             = value[0];
			REG_FULL_MV:    gauge_cfg.full_mv          = value[MV_CFG_W-1:0];
			REG_EMPTY_MV:   gauge_cfg.empty_mv         = value[MV_CFG_W-1:0];
			REG_DETECT_THR: gauge_cfg.detect_threshold = value[THR_W-1:0];
			REG_SAT_LIMIT:  gauge_cfg.saturation_limit = value[SAT_W-1:0];
			REG_CAL_GAIN:   gauge_cfg.cal_gain         = value[CAL_W-1:0];
			REG_CAL_OFFSET: gauge_cfg.cal_offset       = value[CAL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic m, input int unsigned full_v, empty_v, thr,
			sat, gain, off);
		write_reg(REG_MODE, m);
		write_reg(REG_FULL_MV, full_v);
		write_reg(REG_EMPTY_MV, empty_v);
		write_reg(REG_DETECT_THR, thr);
		write_reg(REG_SAT_LIMIT, sat);
		write_reg(REG_CAL_GAIN, gain);
		write_reg(REG_CAL_OFFSET, off);
	endtask

	task automatic add_sample(input int unsigned s, input logic g);
		adc_req_t r;
		r.sample  = s[ADC_W-1:0];
		r.gate_on = g;
		samples_pending.push_back(r);
		samples_queued++;
	endtask

	// all requests fed, all readings in, then let the back end go quiet
	task automatic wait_drained();
		while (samples_pending.size() != 0 || push || readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned near(int base, int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return v;
	endfunction

	task automatic maybe_noise();
		if ($urandom_range(99) < 4)
			add_sample($urandom_range(0, ADC_MAX), 1'($urandom_range(1)));
	endtask

	// four idle then four gated samples, occasionally cut short or disturbed
	task automatic add_measurement();
		int unsigned lo_g, hi_g;
		int ib, gb, jit, n_gated;
		ib  = $urandom_range(0, ADC_MAX);
		jit = $urandom_range(0, 12);
		case ($urandom_range(0, 9))
			0, 1: gb = near(ib, 400);
			2, 3, 4, 5: begin
				if (gauge_cfg.cal_gain != 0) begin
					lo_g = (gauge_cfg.empty_mv + gauge_cfg.cal_offset) * 1000
						/ gauge_cfg.cal_gain;
					hi_g = (gauge_cfg.full_mv + gauge_cfg.cal_offset) * 1000
						/ gauge_cfg.cal_gain + 2;
					if (lo_g > ADC_MAX)
						lo_g = ADC_MAX;
					if (hi_g > ADC_MAX)
						hi_g = ADC_MAX;
					gb = $urandom_range(lo_g, hi_g);
				end else begin
					gb = $urandom_range(0, ADC_MAX);
				end
			end
			default: gb = $urandom_range(0, ADC_MAX);
		endcase
		n_gated = ($urandom_range(99) < 8) ? $urandom_range(0, AVG_N - 1) : AVG_N;
		for (int i = 0; i < AVG_N; i++) begin
			maybe_noise();
			add_sample(near(ib, jit), GATE_OFF);
		end
		for (int i = 0; i < n_gated; i++) begin
			maybe_noise();
			add_sample(near(gb, jit), GATE_ON);
		end
	endtask

	task automatic run_phase(input int n, input bit pause_mid);
		int target;
		bit paused;
		target = samples_queued + n;
		paused = 1'b0;
		while (samples_queued < target) begin
			if (gauge_cfg.mode == MODE_INTERNAL)
				add_sample($urandom_range(1) ? $urandom_range(960, 1400)
					: $urandom_range(0, ADC_MAX), 1'($urandom_range(1)));
			else
				add_measurement();
			if (pause_mid && !paused && samples_queued >= target - n / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		wait_drained();
	endtask

	initial begin
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(REG_SPARE, 32'hFFFF_FFFF);

		// gated sample before any idle set is dropped
		add_sample(ADC_MAX, GATE_ON);
		// idle sample after gating began restarts the measurement
		repeat (4) add_sample(1000, GATE_OFF);
		repeat (2) add_sample(3000, GATE_ON);
		add_sample(2000, GATE_OFF);
		repeat (3) add_sample(1000, GATE_OFF);
		repeat (4) add_sample(3000, GATE_ON);
		// saturated gated average
		repeat (4) add_sample(0, GATE_OFF);
		repeat (4) add_sample(ADC_MAX, GATE_ON);
		wait_drained();
		write_reg(REG_MODE, MODE_INTERNAL);
		add_sample(0, GATE_ON);
		add_sample(ADC_MAX, GATE_OFF);
		wait_drained();

		apply_config(MODE_EXTERNAL, 4200, 3600, 300, 4000, 4242, 6590);
		run_phase(200, 1'b1);
		apply_config(MODE_INTERNAL, 0, 0, 0, 0, 0, 0);
		run_phase(100, 1'b0);
		apply_config(MODE_EXTERNAL, 0, 0, 0, 0, 0, 0);
		run_phase(80, 1'b0);
		apply_config(MODE_EXTERNAL, 8191, 8191, 4095, 4096, 65535, 65535);
		run_phase(80, 1'b0);
		apply_config(MODE_EXTERNAL, 3000, 5000, 100, 4096, 4242, 6590);
		run_phase(100, 1'b0);
		for (int k = 0; k < 4; k++) begin
			int unsigned e;
			e = $urandom_range(2000, 5000);
			apply_config((k == 1) ? MODE_INTERNAL : MODE_EXTERNAL, e + $urandom_range(1, 2000),
				e, $urandom_range(0, 600), $urandom_range(2000, 4096),
				$urandom_range(1000, 65535), $urandom_range(0, 65535));
			steady = (k == 0);
			run_phase(130, 1'b0);
			steady = 1'b0;
		end

		wait_drained();
		if (mismatches == 0)
			$display("PASS battery_level_gauge");
		else
			$display("FAIL battery_level_gauge");
		$finish;
	end

endmodule
